// ===== rtl/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, codes and helpers of the circular byte queue.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W = 4;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_DUMP      = 3'd4;
	localparam logic [2:0] ST_POSITIONS = 3'd5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_DUMP   = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} cmd_t;

	function automatic idx_t next_slot(input idx_t idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [POS_W-1:0] pos_code(input idx_t idx, input logic empty);
		logic [POS_W+IDX_W-1:0] ext;
		ext = {{POS_W{1'b0}}, idx};
		return empty ? {POS_W{1'b1}} : ext[POS_W-1:0];
	endfunction

endpackage

// ===== rtl/cbq_if.sv =====
// ----------------------------------------------------------------------------
// cbq_if
// Request and response channels of the circular byte queue.
// ----------------------------------------------------------------------------
interface cbq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_in;

	modport source (output valid, output op, output data_in, input ready);
	modport sink (input valid, input op, input data_in, output ready);
endinterface

interface cbq_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] data_out;
	logic [3:0] front_pos;
	logic [3:0] rear_pos;
	logic       last;

	modport source (output valid, output status, output data_out, output front_pos,
		output rear_pos, output last, input ready);
	modport sink (input valid, input status, input data_out, input front_pos,
		input rear_pos, input last, output ready);
endinterface

// ===== rtl/cbq_ram.sv =====
// ----------------------------------------------------------------------------
// cbq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cbq_front.sv =====
// ----------------------------------------------------------------------------
// cbq_front
// Accepts request words, decodes the operation and holds them in a
// two-entry queue ahead of the execution stage.
// ----------------------------------------------------------------------------
module cbq_front (
	input  logic          clk,
	input  logic          arst_n,
	cbq_req_if.sink       req,
	output logic          cmd_valid,
	output cbq_pkg::cmd_t cmd,
	input  logic          cmd_ready
);

	cbq_pkg::cmd_t e0_q;
	cbq_pkg::cmd_t e1_q;
	cbq_pkg::cmd_t dec;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	always_comb begin
		dec.data = req.data_in;
		unique case (req.op)
			cbq_pkg::OP_INSERT: dec.kind = cbq_pkg::KIND_INSERT;
			cbq_pkg::OP_DELETE: dec.kind = cbq_pkg::KIND_DELETE;
			cbq_pkg::OP_DUMP:   dec.kind = cbq_pkg::KIND_DUMP;
			default:            dec.kind = cbq_pkg::KIND_QUERY;
		endcase
	end

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				e0_q <= dec;
			end else begin
				e0_q <= e1_q;
			end
			if (push && count_q == 2'd2) begin
				e1_q <= dec;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				e0_q <= dec;
			end else begin
				e1_q <= dec;
			end
		end
	end

endmodule

// ===== rtl/cbq_back.sv =====
// ----------------------------------------------------------------------------
// cbq_back
// Owns the ring and its indices, carries out one command at a time and
// drives the registered response channel.
// ----------------------------------------------------------------------------
module cbq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cbq_pkg::cmd_t cmd,
	output logic          cmd_ready,
	cbq_rsp_if.source     rsp
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_READ = 2'b10
	} bk_state_t;

	bk_state_t       state_q;
	bk_state_t       state_d;
	cbq_pkg::idx_t   head_q, head_d;
	cbq_pkg::idx_t   tail_q, tail_d;
	logic            empty_q, empty_d;
	cbq_pkg::idx_t   rd_addr_q;
	logic [2:0]      pend_status_q, pend_status_d;
	logic            pend_last_q, pend_last_d;
	logic            out_valid_q;
	logic [2:0]      status_q;
	logic [7:0]      data_q;
	logic [3:0]      front_q;
	logic [3:0]      rear_q;
	logic            last_q;
	logic            out_free;
	logic            take;
	logic            emit_rd;
	logic            imm;
	logic [2:0]      imm_status;
	logic            we;
	cbq_pkg::idx_t   waddr;
	logic            re;
	cbq_pkg::idx_t   raddr;
	logic [7:0]      rdata;
	cbq_pkg::idx_t   head_nxt;
	cbq_pkg::idx_t   tail_nxt;
	cbq_pkg::idx_t   rd_nxt;

	cbq_ram #(.WIDTH(8), .DEPTH(cbq_pkg::DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign take      = (state_q == BK_IDLE) && cmd_valid && out_free;
	assign emit_rd   = (state_q == BK_READ) && out_free;
	assign cmd_ready = take;
	assign head_nxt  = cbq_pkg::next_slot(head_q);
	assign tail_nxt  = cbq_pkg::next_slot(tail_q);
	assign rd_nxt    = cbq_pkg::next_slot(rd_addr_q);

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		tail_d        = tail_q;
		empty_d       = empty_q;
		pend_status_d = pend_status_q;
		pend_last_d   = pend_last_q;
		imm           = 1'b0;
		imm_status    = cbq_pkg::ST_POSITIONS;
		we            = 1'b0;
		waddr         = tail_nxt;
		re            = 1'b0;
		raddr         = head_q;
		if (take) begin
			unique case (cmd.kind)
				cbq_pkg::KIND_INSERT: begin
					imm        = 1'b1;
					imm_status = cbq_pkg::ST_INSERTED;
					if (empty_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b0;
						we      = 1'b1;
						waddr   = '0;
					end else if (tail_nxt == head_q) begin
						imm_status = cbq_pkg::ST_OVERFLOW;
					end else begin
						tail_d = tail_nxt;
						we     = 1'b1;
					end
				end
				cbq_pkg::KIND_DELETE: begin
					if (empty_q) begin
						imm        = 1'b1;
						imm_status = cbq_pkg::ST_UNDERFLOW;
					end else begin
						re            = 1'b1;
						state_d       = BK_READ;
						pend_status_d = cbq_pkg::ST_DELETED;
						pend_last_d   = 1'b1;
						if (head_q == tail_q) begin
							empty_d = 1'b1;
							head_d  = '0;
							tail_d  = '0;
						end else begin
							head_d = head_nxt;
						end
					end
				end
				cbq_pkg::KIND_DUMP: begin
					if (empty_q) begin
						imm        = 1'b1;
						imm_status = cbq_pkg::ST_UNDERFLOW;
					end else begin
						re            = 1'b1;
						state_d       = BK_READ;
						pend_status_d = cbq_pkg::ST_DUMP;
						pend_last_d   = (head_q == tail_q);
					end
				end
				default: begin
					imm        = 1'b1;
					imm_status = cbq_pkg::ST_POSITIONS;
				end
			endcase
		end
		if (emit_rd) begin
			if (pend_last_q) begin
				state_d = BK_IDLE;
			end else begin
				re          = 1'b1;
				raddr       = rd_nxt;
				pend_last_d = (rd_nxt == tail_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			if (imm || emit_rd) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_status_q <= pend_status_d;
		pend_last_q   <= pend_last_d;
		if (re) begin
			rd_addr_q <= raddr;
		end
		if (imm) begin
			status_q <= imm_status;
			data_q   <= 8'd0;
			front_q  <= cbq_pkg::pos_code(head_d, empty_d);
			rear_q   <= cbq_pkg::pos_code(tail_d, empty_d);
			last_q   <= 1'b1;
		end else if (emit_rd) begin
			status_q <= pend_status_q;
			data_q   <= rdata;
			front_q  <= cbq_pkg::pos_code(head_q, empty_q);
			rear_q   <= cbq_pkg::pos_code(tail_q, empty_q);
			last_q   <= pend_last_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.data_out  = data_q;
	assign rsp.front_pos = front_q;
	assign rsp.rear_pos  = rear_q;
	assign rsp.last      = last_q;

endmodule

// ===== rtl/circular_byte_queue.sv =====
// ----------------------------------------------------------------------------
// circular_byte_queue
// FIFO of bytes held in a ring, driven by insert, delete, dump and query
// requests.
// ----------------------------------------------------------------------------
// The req channel takes one word per operation: op selects insert, delete,
// dump or query, and data_in carries the byte to insert. The rsp channel
// returns one word per result with status, data_out, front_pos, rear_pos and
// last; last marks the final word of each request.
// A request first enters a two-entry queue, so req stays ready while the
// execution stage works. Insert, query, overflow and underflow register their
// word from the queue entry and can follow one another every cycle while rsp
// is not stalled. Delete reads the ring memory, so its word passes the read
// data register first, and no new request is taken until it is sent. A dump
// of n bytes sends n words, one per cycle while rsp is not stalled.
// Reset empties the queue: both positions read as -1 and nothing is held.
// When rsp is stalled, the response word holds, execution pauses and req
// stays ready until the two-entry queue fills.
// ----------------------------------------------------------------------------
module circular_byte_queue (
	input logic       clk,
	input logic       arst_n,
	cbq_req_if.sink   req,
	cbq_rsp_if.source rsp
);

	logic          cmd_valid;
	logic          cmd_ready;
	cbq_pkg::cmd_t cmd;

	cbq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	cbq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/cbq_checker.sv =====
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks on the response channel of the circular byte queue.
// ----------------------------------------------------------------------------
module cbq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic [7:0] data_out,
	input logic [3:0] front_pos,
	input logic [3:0] rear_pos,
	input logic       last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out)
			&& $stable(front_pos) && $stable(rear_pos) && $stable(last))
		else $error("Response word changed while stalled.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= cbq_pkg::ST_POSITIONS)
		else $error("Undefined status code.");

	a_only_dump_continues: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> status == cbq_pkg::ST_DUMP)
		else $error("Multi-word response that is not a dump.");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != cbq_pkg::ST_DELETED && status != cbq_pkg::ST_DUMP
			|-> data_out == 8'd0)
		else $error("Nonzero data on a status without data.");

	a_empty_both: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (cbq_pkg::DEPTH < 16) && front_pos == 4'hF |-> rear_pos == 4'hF)
		else $error("Only one position shows an empty queue.");

endmodule

bind circular_byte_queue cbq_checker u_cbq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.data_out  (rsp.data_out),
	.front_pos (rsp.front_pos),
	.rear_pos  (rsp.rear_pos),
	.last      (rsp.last)
);
